// ===== hw/rtl/pr_pkg.sv =====
package pr_pkg;

  // Parameter defaults
  localparam int unsigned MsgDepthDef  = 4096;
  localparam int unsigned CountBitsDef = 16;

  // Reset value of the capacity register, before clamping to the buffer depth
  localparam int unsigned CapResetVal = 4096;

  // Header layout (byte positions inside a packet)
  localparam int unsigned OffFirst  = 12;
  localparam int unsigned OffLast   = 14;
  localparam int unsigned LenFirst  = 17;
  localparam int unsigned LenLast   = 19;
  localparam int unsigned CsumFirst = 20;
  localparam int unsigned FoldPos   = 20;
  localparam int unsigned ModPos    = 21;
  localparam int unsigned HdrLast   = 23;
  localparam int unsigned HdrLen    = 24;

  localparam logic [23:0] PosMax     = 24'hFF_FFFF;
  localparam logic [31:0] CsumModulo = 32'hFFFF_FFFF;

  // Output queue depth
  localparam int unsigned OutqDepth = 3;

  typedef enum logic [1:0] {
    CmdByte   = 2'd0,
    CmdRead   = 2'd1,
    CmdFinish = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StInProgress = 3'd0,
    StAccepted   = 3'd1,
    StBadCsum    = 3'd2,
    StBadOffset  = 3'd3,
    StShort      = 3'd4
  } status_e;

  // Result leaving the engine, before the memory read data joins it
  typedef struct packed {
    logic [2:0]  status;
    logic        rd_en;
    logic [15:0] count;
    logic [12:0] length;
  } res_t;

  // Complete result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  rdata;
    logic [15:0] count;
    logic [12:0] length;
  } out_t;

  // Byte lane (shift / 8) of header byte pos inside its checksum field
  function automatic logic [2:0] hdr_lane(input logic [4:0] pos);
    logic [2:0] lane;
    lane = 3'd0;
    case (pos)
      5'd0, 5'd5:          lane = 3'd4;
      5'd1, 5'd6:          lane = 3'd3;
      5'd2, 5'd7, 5'd12,
      5'd17:               lane = 3'd2;
      5'd3, 5'd8, 5'd13,
      5'd15, 5'd18:        lane = 3'd1;
      default:             lane = 3'd0;
    endcase
    return lane;
  endfunction

endpackage

// ===== hw/rtl/pr_ram.sv =====
module pr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pr_engine.sv =====
module pr_engine #(
  parameter int unsigned MSG_DEPTH  = pr_pkg::MsgDepthDef,
  parameter int unsigned COUNT_BITS = pr_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [12:0]                  cfg_data_i,
  input  logic                         accept_i,
  input  logic [1:0]                   command_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  input  logic [11:0]                  read_index_i,
  output logic                         mem_we_o,
  output logic [$clog2(MSG_DEPTH)-1:0] mem_waddr_o,
  output logic [7:0]                   mem_wdata_o,
  output logic                         mem_re_o,
  output logic [$clog2(MSG_DEPTH)-1:0] mem_raddr_o,
  output logic                         s1_valid_o,
  output pr_pkg::res_t                 s1_res_o
);
  import pr_pkg::*;

  localparam int unsigned AW = $clog2(MSG_DEPTH);
  localparam int unsigned CapRst = (MSG_DEPTH < CapResetVal) ? MSG_DEPTH : CapResetVal;
  localparam logic [AW-1:0] CapRstM1 = AW'(CapRst - 1);
  localparam logic [AW-1:0] DepthM1  = AW'(MSG_DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  // Capacity is kept as (effective capacity - 1), clamped at write time
  logic [AW-1:0]         capm1_q, capm1_d;

  logic [23:0]           pos_q, pos_d;
  logic [41:0]           acc_q, acc_d;
  logic [32:0]           fold_q, fold_d;
  logic [31:0]           mod_q, mod_d;
  logic [23:0]           csum_q, csum_d;
  logic [23:0]           off_q, off_d;
  logic [23:0]           tlen_q, tlen_d;
  logic                  good_q, good_d;
  status_e               verdict_q, verdict_d;
  logic [AW-1:0]         widx_q, widx_d;
  logic [AW-1:0]         hw_q, hw_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  s1_valid_q;
  res_t                  s1_res_q, res_d;

  cmd_e                  cmd;
  status_e               status;
  logic [31:0]           fold_sum;

  always_comb begin
    capm1_d = capm1_q;
    if (cfg_we_i) begin
      if (cfg_data_i == 13'd0) begin
        capm1_d = '0;
      end else if (32'(cfg_data_i) > MSG_DEPTH) begin
        capm1_d = DepthM1;
      end else begin
        capm1_d = AW'(cfg_data_i - 13'd1);
      end
    end
  end

  assign fold_sum    = fold_q[31:0] + 32'(fold_q[32]);
  assign mem_raddr_o = AW'(read_index_i);
  assign mem_waddr_o = widx_q;
  assign mem_wdata_o = data_byte_i;

  always_comb begin
    cmd       = cmd_e'(command_i);
    status    = StInProgress;
    pos_d     = pos_q;
    acc_d     = acc_q;
    fold_d    = fold_q;
    mod_d     = mod_q;
    csum_d    = csum_q;
    off_d     = off_q;
    tlen_d    = tlen_q;
    good_d    = good_q;
    verdict_d = verdict_q;
    widx_d    = widx_q;
    hw_d      = hw_q;
    cnt_d     = cnt_q;
    res_d     = '0;
    mem_we_o  = 1'b0;
    mem_re_o  = 1'b0;

    if (accept_i) begin
      unique case (cmd)
        CmdByte: begin
          if (pos_q < 24'(CsumFirst)) begin
            acc_d = acc_q + (42'(data_byte_i) << {hdr_lane(pos_q[4:0]), 3'b000});
            if (pos_q >= 24'(OffFirst) && pos_q <= 24'(OffLast)) begin
              off_d = {off_q[15:0], data_byte_i};
            end
            if (pos_q >= 24'(LenFirst) && pos_q <= 24'(LenLast)) begin
              tlen_d = {tlen_q[15:0], data_byte_i};
            end
          end else if (pos_q < 24'(HdrLen)) begin
            csum_d = {csum_q[15:0], data_byte_i};
            // end-around fold of the 42-bit sum, spread over two bytes
            if (pos_q == 24'(FoldPos)) begin
              fold_d = {1'b0, acc_q[31:0]} + 33'(acc_q[41:32]);
            end
            if (pos_q == 24'(ModPos)) begin
              mod_d = (fold_sum == CsumModulo) ? 32'd0 : fold_sum;
            end
            if (pos_q == 24'(HdrLast)) begin
              if (mod_q != {csum_q, data_byte_i}) begin
                verdict_d = StBadCsum;
              end else if (off_q > 24'(capm1_q)) begin
                verdict_d = StBadOffset;
              end else begin
                verdict_d = StAccepted;
              end
              good_d = (verdict_d == StAccepted);
              widx_d = AW'(off_q);
            end
          end else if (good_q && pos_q < tlen_q && widx_q < capm1_q) begin
            mem_we_o = 1'b1;
            widx_d   = widx_q + 1'b1;
            if (widx_q > hw_q) begin
              hw_d = widx_q;
            end
          end
          if (pos_q != PosMax) begin
            pos_d = pos_q + 24'd1;
          end
          if (last_byte_i) begin
            status = (pos_q < 24'(HdrLast)) ? StShort : verdict_d;
            if (status == StAccepted && cnt_q != CntMax) begin
              cnt_d = cnt_q + 1'b1;
            end
            res_d.status = status;
            pos_d     = '0;
            acc_d     = '0;
            csum_d    = '0;
            off_d     = '0;
            tlen_d    = '0;
            good_d    = 1'b0;
            verdict_d = StInProgress;
          end
        end
        CmdRead: begin
          mem_re_o    = 1'b1;
          res_d.rd_en = (32'(read_index_i) < MSG_DEPTH);
        end
        CmdFinish: begin
          res_d.count  = 16'(cnt_q);
          res_d.length = 13'(32'(hw_q) + 32'd1);
          cnt_d     = '0;
          hw_d      = '0;
          pos_d     = '0;
          acc_d     = '0;
          csum_d    = '0;
          off_d     = '0;
          tlen_d    = '0;
          good_d    = 1'b0;
          verdict_d = StInProgress;
        end
        CmdNop: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capm1_q    <= CapRstM1;
      pos_q      <= '0;
      acc_q      <= '0;
      csum_q     <= '0;
      off_q      <= '0;
      tlen_q     <= '0;
      good_q     <= 1'b0;
      verdict_q  <= StInProgress;
      widx_q     <= '0;
      hw_q       <= '0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      capm1_q    <= capm1_d;
      pos_q      <= pos_d;
      acc_q      <= acc_d;
      csum_q     <= csum_d;
      off_q      <= off_d;
      tlen_q     <= tlen_d;
      good_q     <= good_d;
      verdict_q  <= verdict_d;
      widx_q     <= widx_d;
      hw_q       <= hw_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q   <= fold_d;
    mod_q    <= mod_d;
    s1_res_q <= res_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_res_o   = s1_res_q;

  a_write_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (mem_waddr_o < capm1_q))
    else $error("payload write at or past capacity-1");

  a_good_means_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_q |-> (verdict_q == StAccepted))
    else $error("packet marked good without accepted verdict");

endmodule

// ===== hw/rtl/pr_out_fifo.sv =====
module pr_out_fifo (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  pr_pkg::out_t                           push_data_i,
  input  logic                                   pop_i,
  output logic                                   valid_o,
  output pr_pkg::out_t                           head_o,
  output logic [$clog2(pr_pkg::OutqDepth+1)-1:0] level_o
);
  import pr_pkg::*;

  localparam int unsigned PW = $clog2(OutqDepth);
  localparam int unsigned CW = $clog2(OutqDepth + 1);
  localparam logic [PW-1:0] PtrLast = PW'(OutqDepth - 1);

  out_t          entry_q [OutqDepth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          pop;

  assign pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign level_o = count_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(OutqDepth))
    else $error("output queue count past depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && count_q == CW'(OutqDepth)) |-> pop)
    else $error("push into full output queue");

endmodule

// ===== hw/rtl/packet_reassembler_top.sv =====
// Packet reassembler. Takes one transaction per clock on the input channel
// while in_stall_o is low: a packet byte (command 0), a message read (1), a
// finish-and-report (2) or a no-op (3); every input transaction yields exactly
// one result transaction. The first 24 bytes of a packet are the header; its
// fields are summed modulo 2^32-1 and checked against the stored checksum, and
// the fragment offset is checked against capacity-1. Payload bytes of an
// accepted packet land in the message memory at offset+j, stopping at
// capacity-1 or at the total length. A result passes the registered read of
// the message memory and then the output queue before it shows on the output.
// A three-entry output queue lets the input keep running while the output is
// stalled; in_stall_o rises once three results are pending and drops as soon
// as one is taken. There is no clearing pass after reset: the message memory
// is undefined until written and reading an unwritten location returns an
// unspecified byte. message_capacity is written through cfg_we_i/cfg_data_i;
// the user must write it only while the block is idle, and the block has no
// check for that. 0 acts as 1 and values above MSG_DEPTH act as MSG_DEPTH.
module packet_reassembler_top #(
  parameter int unsigned MSG_DEPTH  = pr_pkg::MsgDepthDef,
  parameter int unsigned COUNT_BITS = pr_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration (message_capacity)
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [11:0] read_index_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  packet_status_o,
  output logic [7:0]  read_data_o,
  output logic [15:0] rebuilt_count_o,
  output logic [12:0] message_length_o
);
  import pr_pkg::*;

  localparam int unsigned AW = $clog2(MSG_DEPTH);
  localparam int unsigned LW = $clog2(OutqDepth + 1);

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          s1_valid;
  res_t          s1_res;
  out_t          s1_out;
  out_t          head;
  logic [LW-1:0] q_level;
  logic [LW:0]   occupancy;

  // Credit check: results in flight (memory stage plus queue) must leave room
  // for one more. Only registered state feeds in_stall_o, so there is no
  // combinational path from out_stall_i to the input side.
  assign occupancy  = (LW + 1)'(s1_valid) + (LW + 1)'(q_level);
  assign in_stall_o = (occupancy >= (LW + 1)'(OutqDepth));
  assign accept     = in_valid_i && !in_stall_o;

  // Header parsing, checksum, payload address generation and counters
  pr_engine #(
    .MSG_DEPTH  (MSG_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .read_index_i (read_index_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .s1_valid_o   (s1_valid),
    .s1_res_o     (s1_res)
  );

  // Message store. Writes and reads both happen on the accept edge of their
  // own transaction, so program order is kept without forwarding.
  pr_ram #(
    .WIDTH (8),
    .DEPTH (MSG_DEPTH)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Memory stage: read data joins the rest of the result here
  always_comb begin
    s1_out.status = s1_res.status;
    s1_out.rdata  = s1_res.rd_en ? mem_rdata : 8'd0;
    s1_out.count  = s1_res.count;
    s1_out.length = s1_res.length;
  end

  pr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid),
    .push_data_i (s1_out),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .head_o      (head),
    .level_o     (q_level)
  );

  assign packet_status_o  = head.status;
  assign read_data_o      = head.rdata;
  assign rebuilt_count_o  = head.count;
  assign message_length_o = head.length;

  // The credit scheme never lets more results be in flight than the queue holds
  a_inflight_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= (LW + 1)'(OutqDepth))
    else $error("results in flight exceed output queue depth");

endmodule

// ===== verif/tb_packet_reassembler_top.sv =====
module tb_packet_reassembler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pr_pkg::*;

  // CycleLimit sits well above the slowest correct run, even with either side
  // idling 78% of the time; ~1250 transactions plus the hold-off.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned MsgDepth   = MsgDepthDef;
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned NumPhases  = 6;

  typedef enum {CsumGood, CsumFlip, CsumOnes} csum_mode_e;

  // One input transaction as it appears on the input channel
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  data;
    logic        last;
    logic [11:0] ridx;
  } frag_txn_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [12:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic [1:0]  command_i    = '0;
  logic [7:0]  data_byte_i  = '0;
  logic        last_byte_i  = 1'b0;
  logic [11:0] read_index_i = '0;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  packet_status_o;
  logic [7:0]  read_data_o;
  logic [15:0] rebuilt_count_o;
  logic [12:0] message_length_o;

  packet_reassembler_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .packet_status_o  (packet_status_o),
    .read_data_o      (read_data_o),
    .rebuilt_count_o  (rebuilt_count_o),
    .message_length_o (message_length_o)
  );

  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  frag_txn_t   byte_cmd_q[$];     // transactions waiting for the driver
  out_t        reply_q[$];        // predicted results, oldest first
  frag_txn_t   drv_txn;           // transaction currently on the input port
  int unsigned n_pushed   = 0;    // written by the stimulus process only
  int unsigned n_in       = 0;    // accepted input transactions
  int unsigned n_out      = 0;    // checked result transactions
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned gap_pct    = 0;    // sender idle chance per cycle
  int unsigned stall_pct  = 0;    // receiver stall chance per cycle
  logic        hold_go    = 1'b0;
  int unsigned hold_left  = 0;
  logic [12:0] cap_reg    = 13'(CapResetVal);

  // Reassembler state as the testbench sees it
  logic [23:0] m_pos      = '0;
  logic [41:0] m_sum      = '0;
  logic [31:0] m_csum     = '0;
  logic [23:0] m_off      = '0;
  logic [23:0] m_tlen     = '0;
  logic        m_good     = 1'b0;
  status_e     m_verdict  = StInProgress;
  logic [11:0] m_high     = '0;
  logic [15:0] m_count    = '0;
  logic [7:0]  m_store [MsgDepth];
  bit          m_written [MsgDepth];
  int unsigned written_idx[$];    // every store location written so far
  int unsigned n_accepted = 0;
  int unsigned n_rejected = 0;

  function automatic int unsigned eff_cap(logic [12:0] c);
    if (c == 0) return 1;
    if (c > MsgDepth) return MsgDepth;
    return c;
  endfunction

  // Left shift of header byte p inside its checksum field (big-endian fields
  // of 5, 5, 1, 1, 3, 2 and 3 bytes)
  function automatic int unsigned field_shift(int unsigned p);
    case (p)
      0, 5:                return 32;
      1, 6:                return 24;
      2, 7, 12, 17:        return 16;
      3, 8, 13, 15, 18:    return 8;
      default:             return 0;
    endcase
  endfunction

  function automatic void drop_packet();
    m_pos     = '0;
    m_sum     = '0;
    m_csum    = '0;
    m_off     = '0;
    m_tlen    = '0;
    m_good    = 1'b0;
    m_verdict = StInProgress;
  endfunction

  // Advances the reassembler state by one accepted transaction and returns
  // the result it must produce.
  function automatic out_t reasm_step(frag_txn_t t);
    out_t            r;
    longint unsigned j;
    longint unsigned idx;
    int unsigned     ec;
    r  = '0;
    ec = eff_cap(cap_reg);
    case (t.cmd)
      CmdByte: begin
        if (m_pos < CsumFirst) begin
          m_sum = m_sum + (42'(t.data) << field_shift(m_pos));
          if (m_pos >= OffFirst && m_pos <= OffLast) m_off = {m_off[15:0], t.data};
          if (m_pos >= LenFirst && m_pos <= LenLast) m_tlen = {m_tlen[15:0], t.data};
        end else if (m_pos < HdrLen) begin
          m_csum = {m_csum[23:0], t.data};
          if (m_pos == HdrLast) begin
            if (64'(m_sum) % 64'(CsumModulo) != 64'(m_csum)) begin
              m_verdict = StBadCsum;
            end else if (m_off > ec - 1) begin
              m_verdict = StBadOffset;
            end else begin
              m_verdict = StAccepted;
            end
            m_good = (m_verdict == StAccepted);
          end
        end else if (m_good && m_tlen > HdrLen) begin
          j   = 64'(m_pos) - 64'(HdrLen);
          idx = 64'(m_off) + j;
          // payload stops at the total length and one short of capacity
          if (j < m_tlen - HdrLen && idx < ec - 1) begin
            m_store[12'(idx)] = t.data;
            if (!m_written[12'(idx)]) begin
              m_written[12'(idx)] = 1'b1;
              written_idx.push_back(32'(idx));
            end
            if (idx > m_high) m_high = 12'(idx);
          end
        end
        if (m_pos != PosMax) m_pos = m_pos + 24'd1;
        if (t.last) begin
          r.status = (m_pos < HdrLen) ? 3'(StShort) : 3'(m_verdict);
          if (r.status == StAccepted) begin
            n_accepted++;
            if (m_count != '1) m_count = m_count + 16'd1;
          end else begin
            n_rejected++;
          end
          drop_packet();
        end
      end
      CmdRead: begin
        r.rdata = m_store[t.ridx];
      end
      CmdFinish: begin
        r.count  = m_count;
        r.length = 13'(m_high) + 13'd1;
        m_count  = '0;
        m_high   = '0;
        drop_packet();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_err(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("MISMATCH result %0d %s: got %0d want %0d", n_out, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction per cycle at most; a stalled transaction is held.
  // The predictor runs on the transaction at the edge that accepts it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        reply_q.push_back(reasm_step(drv_txn));
        n_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (byte_cmd_q.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          drv_txn      = byte_cmd_q.pop_front();
          in_valid_i   <= 1'b1;
          command_i    <= drv_txn.cmd;
          data_byte_i  <= drv_txn.data;
          last_byte_i  <= drv_txn.last;
          read_index_i <= drv_txn.ridx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the stimulus process only has to
  // pulse hold_go for one edge.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_left <= HoldCycles;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each taken result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (reply_q.size() == 0) begin
          report_err("unexpected result, status", packet_status_o, 0);
        end else begin
          want = reply_q.pop_front();
          if (packet_status_o !== want.status)
            report_err("packet_status", packet_status_o, want.status);
          if (read_data_o !== want.rdata)
            report_err("read_data", read_data_o, want.rdata);
          if (rebuilt_count_o !== want.count)
            report_err("rebuilt_count", rebuilt_count_o, want.count);
          if (message_length_o !== want.length)
            report_err("message_length", message_length_o, want.length);
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99, 0) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout: %0d of %0d transactions in, %0d results pending",
               n_in, n_pushed, reply_q.size());
      $display("tb_packet_reassembler_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_item(cmd_e c, logic [7:0] d, logic l, logic [11:0] ri);
    frag_txn_t t;
    t.cmd  = c;
    t.data = d;
    t.last = l;
    t.ridx = ri;
    byte_cmd_q.push_back(t);
    n_pushed++;
  endfunction

  // Read, finish and no-op carry random junk in the fields they ignore,
  // last_byte included.
  function automatic void push_read(int unsigned ri);
    push_item(CmdRead, 8'($urandom), 1'($urandom), 12'(ri));
  endfunction

  function automatic void push_other(cmd_e c);
    push_item(c, 8'($urandom), 1'($urandom), 12'($urandom));
  endfunction

  // Builds one packet: a 24-byte header with offset, total length and
  // checksum, then random payload. nbytes below 24 gives a short packet;
  // close = 0 leaves it open (no last byte).
  function automatic void push_packet(logic [23:0] off, logic [23:0] tlen,
                                      int unsigned nbytes, csum_mode_e mode,
                                      bit ones, bit close);
    logic [7:0]      hb [HdrLen];
    longint unsigned sum;
    logic [31:0]     cs;
    for (int unsigned p = 0; p < CsumFirst; p++) hb[p] = ones ? 8'hFF : 8'($urandom);
    {hb[12], hb[13], hb[14]} = off;
    {hb[17], hb[18], hb[19]} = tlen;
    sum = 0;
    for (int unsigned p = 0; p < CsumFirst; p++) sum += longint'(hb[p]) << field_shift(p);
    cs = 32'(sum % 64'(CsumModulo));
    case (mode)
      CsumFlip: cs = cs ^ (32'd1 << $urandom_range(31, 0));
      CsumOnes: cs = '1;   // never a valid residue
      default: ;
    endcase
    {hb[20], hb[21], hb[22], hb[23]} = cs;
    for (int unsigned p = 0; p < nbytes; p++)
      push_item(CmdByte, (p < HdrLen) ? hb[p] : 8'($urandom),
                close && (p == nbytes - 1), 12'($urandom));
  endfunction

  // Sender pause: returns once everything pushed is accepted and answered.
  task automatic wait_drained();
    @(posedge clk_i);
    while (n_in != n_pushed || reply_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [12:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    cap_reg    = v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One random packet or command, shaped around the effective capacity ec
  task automatic push_random(int unsigned ec);
    int unsigned pick;
    int unsigned plen;
    int unsigned nb;
    int unsigned span;
    logic [23:0] off;
    logic [23:0] tlen;
    pick = $urandom_range(99, 0);
    plen = $urandom_range(16, 0);
    tlen = 24'(HdrLen + plen);
    case ($urandom_range(9, 0))
      0: tlen = 24'($urandom_range(HdrLen - 1, 0));
      1: tlen = 24'($urandom_range(24'hFF_FFFF, 0));
      default: ;
    endcase
    nb = HdrLen + $urandom_range(plen + 3, 0);
    span = (ec - 1 < 20) ? ec - 1 : 20;
    case ($urandom_range(3, 0))
      0: off = 24'($urandom_range(ec - 1, 0));
      1: off = 24'(ec - 1 - $urandom_range(span, 0));   // payload runs into capacity
      default: off = 24'($urandom_range((ec > 64) ? 63 : ec - 1, 0));
    endcase
    if (pick < 55) begin
      push_packet(off, tlen, nb, CsumGood, 1'b0, 1'b1);
    end else if (pick < 63) begin
      push_packet(off, tlen, nb, ($urandom_range(4, 0) == 0) ? CsumOnes : CsumFlip,
                  1'b0, 1'b1);
    end else if (pick < 68) begin
      off = ($urandom_range(1, 0) == 0) ? 24'(ec + $urandom_range(3, 0))
                                        : 24'($urandom_range(24'hFF_FFFF, ec));
      push_packet(off, tlen, nb, CsumGood, 1'b0, 1'b1);
    end else if (pick < 73) begin
      push_packet(off, tlen, $urandom_range(HdrLen - 1, 1), CsumGood, 1'b0, 1'b1);
    end else if (pick < 87) begin
      repeat ($urandom_range(4, 1)) begin
        if (written_idx.size() != 0)
          push_read(written_idx[$urandom_range(written_idx.size() - 1, 0)]);
        else
          push_other(CmdNop);
      end
    end else if (pick < 93) begin
      push_other(CmdFinish);
    end else if (pick < 96) begin
      // packet cut short by a finish
      push_packet(off, tlen, $urandom_range(30, 1), CsumGood, 1'b0, 1'b0);
      push_other(CmdFinish);
    end else begin
      push_other(CmdNop);
    end
  endtask

  logic [12:0] phase_cap   [NumPhases] = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd300,
                                           13'd4096};
  int unsigned phase_gap   [NumPhases] = '{0, 78, 0, 13, 0, 13};
  int unsigned phase_stall [NumPhases] = '{0, 0, 78, 13, 0, 13};

  initial begin
    int unsigned start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity of 4096, no idling.
    push_other(CmdNop);
    push_item(CmdFinish, 8'hFF, 1'b1, 12'hFFF);          // empty report, last ignored
    push_packet(24'd0, 24'd0, 1, CsumGood, 1'b0, 1'b1);   // one-byte packet
    push_packet(24'd0, 24'd40, 23, CsumGood, 1'b0, 1'b1); // one byte short of header
    push_packet(24'd0, 24'd28, 30, CsumGood, 1'b0, 1'b1); // extra bytes past length
    push_packet(24'd4090, 24'd34, 34, CsumGood, 1'b0, 1'b1); // clipped at capacity-1
    push_packet(24'd5, 24'd100, 24, CsumGood, 1'b0, 1'b1);   // header only
    push_packet(24'd7, 24'd0, 30, CsumGood, 1'b0, 1'b1);     // zero total length
    push_packet(24'd10, 24'd30, 30, CsumFlip, 1'b0, 1'b1);
    push_packet(24'd20, 24'd30, 26, CsumOnes, 1'b0, 1'b1);
    push_packet(24'hFF_FFFF, 24'hFF_FFFF, 26, CsumGood, 1'b1, 1'b1); // all-ones header
    push_packet(24'd4096, 24'd30, 30, CsumGood, 1'b0, 1'b1); // offset equal to capacity
    push_packet(24'd4095, 24'd40, 30, CsumGood, 1'b0, 1'b1); // last legal offset
    push_packet(24'd0, 24'd30, 10, CsumGood, 1'b0, 1'b0);    // dropped by finish
    push_item(CmdFinish, 8'h00, 1'b0, 12'h000);
    push_other(CmdFinish);
    push_item(CmdNop, 8'hFF, 1'b1, 12'hFFF);
    wait_drained();
    foreach (written_idx[k]) push_read(written_idx[k]);
    push_item(CmdRead, 8'h00, 1'b1, 12'(written_idx[0]));
    push_other(CmdFinish);
    wait_drained();

    // Random phases; each starts from an idle block so the capacity write
    // is safe.
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) write_capacity(phase_cap[ph]);
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) begin
        // receiver holds off while the sender keeps going: fills the
        // output queue and pushes back on the input
        @(posedge clk_i);
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      start = n_pushed;
      while (n_pushed - start < PhaseItems) begin
        while (byte_cmd_q.size() > 12) @(posedge clk_i);
        push_random(eff_cap(cap_reg));
      end
      push_other(CmdFinish);
      wait_drained();
    end

    gap_pct   = 0;
    stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d transactions / %0d results over %0d capacity settings", n_in,
             n_out, NumPhases);
    $display("  %0d packets accepted, %0d rejected, %0d store locations written",
             n_accepted, n_rejected, written_idx.size());
    if (err_cnt == 0) begin
      $display("tb_packet_reassembler_top OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb_packet_reassembler_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pr_pkg.sv
hw/rtl/pr_ram.sv
hw/rtl/pr_engine.sv
hw/rtl/pr_out_fifo.sv
hw/rtl/packet_reassembler_top.sv
verif/tb_packet_reassembler_top.sv
